[hdl/etre_pkg.sv]
// package for the event trace record encoder
// holds command codes, record tag bytes, sizes and the controller/datapath structs
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package etre_pkg;

    // default and upper bound of the process count
    localparam int PROCESSES_DEF = 16;
    localparam int PROCESSES_MAX = 32;
    // processes carried by the process_states field
    localparam int FIELD_PROCS   = 16;

    // record sizes in bytes
    localparam int HDR_BYTES = 3;
    localparam int LEN_W     = $clog2(HDR_BYTES + (PROCESSES_MAX + 3) / 4 + 1);

    // event command codes
    localparam logic [3:0] CMD_TIMER    = 4'd0;
    localparam logic [3:0] CMD_MOUSE    = 4'd1;
    localparam logic [3:0] CMD_KEYBOARD = 4'd2;
    localparam logic [3:0] CMD_SERIAL   = 4'd3;
    localparam logic [3:0] CMD_RX_CHAR  = 4'd4;
    localparam logic [3:0] CMD_TX_CHAR  = 4'd5;
    localparam logic [3:0] CMD_SYSCALL  = 4'd6;
    localparam logic [3:0] CMD_START    = 4'd7;
    localparam logic [3:0] CMD_END      = 4'd8;
    localparam logic [3:0] CMD_STATE    = 4'd9;

    // record tag bytes
    localparam logic [7:0] TAG_TIMER   = 8'h54; // 'T'
    localparam logic [7:0] TAG_MOUSE   = 8'h4D; // 'M'
    localparam logic [7:0] TAG_KEY     = 8'h4B; // 'K'
    localparam logic [7:0] TAG_CHAR    = 8'h43; // 'C'
    localparam logic [7:0] TAG_SYSCALL = 8'h53; // 'S'
    localparam logic [7:0] TAG_END     = 8'h5A; // 'Z'
    localparam logic [7:0] TAG_INIT    = 8'h49; // 'I'
    localparam logic [7:0] TAG_EDIT    = 8'h45; // 'E'
    localparam logic [7:0] TAG_NONE    = 8'h4E; // 'N'

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic shift;
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic [LEN_W-1:0] rec_len;
    } t_dp_stat;

endpackage

`default_nettype wire

[hdl/etre_if.sv]
// channel interfaces of the event trace record encoder
// event input, trace byte output and enable register write channel
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface etre_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  command;
    logic [15:0] event_value;
    logic [15:0] timer_count;
    logic [31:0] process_states;

    modport source (output valid, command, event_value, timer_count, process_states,
                    input ready);
    modport sink   (input valid, command, event_value, timer_count, process_states,
                    output ready);
endinterface

interface etre_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] trace_byte;
    logic       last_byte;

    modport source (output valid, trace_byte, last_byte, input ready);
    modport sink   (input valid, trace_byte, last_byte, output ready);
endinterface

interface etre_cfg_if;
    logic valid;
    logic ready;
    logic trace_enable;

    modport source (output valid, trace_enable, input ready);
    modport sink   (input valid, trace_enable, output ready);
endinterface

`default_nettype wire

[hdl/event_trace_record_encoder_top.sv]
// top level of the event trace record encoder
// an event is accepted, then its N trace bytes follow one per cycle while the output is ready,
// N = 3 for a plain record, 4 with a key or syscall byte, 3 + ceil(PROCESSES/4) for changed states
// first byte is offered the cycle after accept; the single output byte port sets the rate
// disabled or silent events emit no bytes; reset clears enable and the stored states to free
`timescale 1ns / 1ps
`default_nettype none

module event_trace_record_encoder_top import etre_pkg::*; #(
    parameter int PROCESSES = PROCESSES_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    etre_in_if.sink    i_evt,
    etre_out_if.source o_rec,
    etre_cfg_if.sink   i_cfg
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // register writes are always taken
    assign i_cfg.ready = 1'b1;

    // controller
    etre_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_evt.valid),
        .o_in_ready  (i_evt.ready),
        .o_out_valid (o_rec.valid),
        .i_out_ready (o_rec.ready),
        .o_last_byte (o_rec.last_byte),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // datapath
    etre_dp #(
        .PROCESSES (PROCESSES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_cfg_we         (i_cfg.valid),
        .i_cfg_enable     (i_cfg.trace_enable),
        .i_command        (i_evt.command),
        .i_event_value    (i_evt.event_value),
        .i_timer_count    (i_evt.timer_count),
        .i_process_states (i_evt.process_states),
        .o_trace_byte     (o_rec.trace_byte)
    );

endmodule

`default_nettype wire

[hdl/etre_ctrl.sv]
// controller of the event trace record encoder
// one-hot state machine and byte counter, drives load and shift commands
// depends on etre_pkg
`timescale 1ns / 1ps
`default_nettype none

module etre_ctrl import etre_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output logic          o_last_byte,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EMIT = 2'b10
    } t_state;

    t_state           r_state, n_state;
    logic [LEN_W-1:0] r_left, n_left;
    logic             w_in_acc;
    logic             w_out_acc;

    // handshakes
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_EMIT);
    assign o_last_byte = (r_left == LEN_W'(1));
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_acc   = o_out_valid && i_out_ready;

    // datapath commands
    assign o_cmd.load  = w_in_acc;
    assign o_cmd.shift = w_out_acc;

    // next state and remaining byte count
    always_comb begin
        n_state = r_state;
        n_left  = r_left;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc && (i_stat.rec_len != '0)) begin
                    n_state = S_EMIT;
                    n_left  = i_stat.rec_len;
                end
            end
            S_EMIT: begin
                if (w_out_acc) begin
                    n_left = r_left - LEN_W'(1);
                    if (o_last_byte) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
                n_left  = '0;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_left  <= '0;
        end else begin
            r_state <= n_state;
            r_left  <= n_left;
        end
    end

endmodule

`default_nettype wire

[hdl/etre_dp.sv]
// datapath of the event trace record encoder
// enable register, stored process states, record builder and byte shift register
// depends on etre_pkg
`timescale 1ns / 1ps
`default_nettype none

module etre_dp import etre_pkg::*; #(
    parameter int PROCESSES = PROCESSES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_dp_cmd     i_cmd,
    output t_dp_stat         o_stat,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_enable,
    input  wire logic [3:0]  i_command,
    input  wire logic [15:0] i_event_value,
    input  wire logic [15:0] i_timer_count,
    input  wire logic [31:0] i_process_states,
    output logic [7:0]       o_trace_byte
);

    localparam int NB = (PROCESSES + 3) / 4;      // packed state bytes
    localparam int PW = 2 * PROCESSES;            // state vector width
    localparam int SW = (HDR_BYTES + NB) * 8;     // longest record width

    logic          r_enable;
    logic [PW-1:0] r_prev;
    logic [SW-1:0] r_shift;

    logic [PW-1:0]   w_cur;
    logic [NB*8-1:0] w_pay;
    logic            w_changed;
    logic            w_is_state;
    logic [7:0]      w_tag;
    logic [7:0]      w_extra;
    logic [SW-1:0]   w_rec;

    // current states, process 0 in the top bits, processes past the field read free
    for (genvar gi = 0; gi < PROCESSES; gi++) begin : g_cur
        if (gi < FIELD_PROCS) begin : g_in
            assign w_cur[PW-1-2*gi -: 2] = i_process_states[31-2*gi -: 2];
        end else begin : g_free
            assign w_cur[PW-1-2*gi -: 2] = 2'b00;
        end
    end

    // packed payload, unused slots of the last byte are zero
    assign w_pay = (NB*8)'(w_cur) << (NB*8 - PW);

    // change detect: start compares against a cleared copy
    assign w_is_state = (i_command == CMD_START) || (i_command == CMD_STATE);
    assign w_changed  = (i_command == CMD_START) ? (w_cur != '0) : (w_cur != r_prev);

    // tag, payload byte, record length
    always_comb begin
        w_tag          = TAG_TIMER;
        w_extra        = i_event_value[7:0];
        o_stat.rec_len = LEN_W'(HDR_BYTES);
        case (i_command)
            CMD_TIMER:  w_tag = TAG_TIMER;
            CMD_MOUSE:  w_tag = TAG_MOUSE;
            CMD_SERIAL: w_tag = TAG_KEY;
            CMD_END:    w_tag = TAG_END;
            CMD_KEYBOARD: begin
                if (i_event_value == '0) begin
                    w_tag = TAG_KEY;
                end else begin
                    w_tag          = TAG_CHAR;
                    o_stat.rec_len = LEN_W'(HDR_BYTES + 1);
                end
            end
            CMD_SYSCALL: begin
                w_tag          = TAG_SYSCALL;
                w_extra        = {i_event_value[11:8], i_event_value[3:0]};
                o_stat.rec_len = LEN_W'(HDR_BYTES + 1);
            end
            CMD_START, CMD_STATE: begin
                if (w_changed) begin
                    w_tag          = (i_command == CMD_START) ? TAG_INIT : TAG_EDIT;
                    o_stat.rec_len = LEN_W'(HDR_BYTES + NB);
                end else begin
                    w_tag = TAG_NONE;
                end
            end
            default: o_stat.rec_len = '0;
        endcase
        if (!r_enable) begin
            o_stat.rec_len = '0;
        end
    end

    // record image, first byte in the top bits
    always_comb begin
        w_rec = SW'({w_tag, i_timer_count}) << (SW - 24);
        if (w_is_state && w_changed) begin
            w_rec = {w_tag, i_timer_count, w_pay};
        end else if (o_stat.rec_len == LEN_W'(HDR_BYTES + 1)) begin
            w_rec = SW'({w_tag, i_timer_count, w_extra}) << (SW - 32);
        end
    end

    assign o_trace_byte = r_shift[SW-1 -: 8];

    // enable register and stored process states
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_prev   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_enable <= i_cfg_enable;
            end
            if (i_cmd.load && r_enable && w_is_state) begin
                r_prev <= w_cur;
            end
        end
    end

    // record shift register, one byte out per output transaction
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_shift <= w_rec;
        end else if (i_cmd.shift) begin
            r_shift <= r_shift << 8;
        end
    end

endmodule

`default_nettype wire

[verif/tb_event_trace_record_encoder_top.sv]
// self-checking testbench for event_trace_record_encoder_top
// uses etre_pkg and the channel interfaces in etre_if; a directed table, then random traffic
// checked byte by byte against the table or an in-bench encoder keeping its own process states
`timescale 1ns / 1ps

module tb_event_trace_record_encoder_top;
    import etre_pkg::*;

    localparam int PROCS        = PROCESSES_DEF;
    localparam int REC_MAX      = HDR_BYTES + (PROCS + 3) / 4;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int PREDICT      = -1;

    // command codes the block ignores
    localparam logic [3:0] CMD_UNUSED_LO = 4'd10;
    localparam logic [3:0] CMD_UNUSED_HI = 4'd15;

    typedef struct packed {
        logic [7:0] byte_val;
        logic       is_last;
    } t_trace_byte;

    // one stimulus row; nexp of PREDICT means the encoder model supplies the record
    typedef struct {
        logic        en;
        logic [3:0]  cmd;
        logic [15:0] val;
        logic [15:0] cnt;
        logic [31:0] ps;
        int          nexp;
        logic [55:0] exp;
    } t_event_row;

    logic clk;
    logic rst_n;

    etre_in_if  evt_if ();
    etre_out_if rec_if ();
    etre_cfg_if cfg_if ();

    event_trace_record_encoder_top #(.PROCESSES(PROCS)) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_evt   (evt_if),
        .o_rec   (rec_if),
        .i_cfg   (cfg_if)
    );

    // encoder model state
    logic        trace_en;
    logic [1:0]  stored_states [0:PROCS-1];
    logic [7:0]  rec_bytes [0:REC_MAX-1];

    t_trace_byte trace_expect [$];
    t_event_row  event_plan [$];

    int          err_count    = 0;
    int          hold_request = 0;
    int          rush_left    = 0;
    int          source_burst = 0;
    int          sink_burst   = 0;
    logic [31:0] last_states  = 32'h0;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // idle cycles before one transaction, with runs of back-to-back transactions
    function automatic int draw_gap(inout int burst);
        if (burst > 0) begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 7) == 0) begin
            burst = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 13);
    endfunction

    // state of one process; processes past the field read as free
    function automatic logic [1:0] proc_state(input logic [31:0] ps, input int idx);
        if (idx >= FIELD_PROCS) return 2'b00;
        return ps[31 - 2 * idx -: 2];
    endfunction

    // builds the record for one event into rec_bytes, returns its length
    function automatic int encode_event(input logic [3:0] cmd, input logic [15:0] val,
                                        input logic [15:0] cnt, input logic [31:0] ps);
        int         n;
        logic       changed;
        logic [1:0] s;
        logic [7:0] tag;
        logic [7:0] packed_b;
        if (!trace_en) return 0;
        case (cmd)
            CMD_TIMER:    tag = TAG_TIMER;
            CMD_MOUSE:    tag = TAG_MOUSE;
            CMD_KEYBOARD: tag = (val == 16'h0000) ? TAG_KEY : TAG_CHAR;
            CMD_SERIAL:   tag = TAG_KEY;
            CMD_SYSCALL:  tag = TAG_SYSCALL;
            CMD_END:      tag = TAG_END;
            CMD_START, CMD_STATE: begin
                // start wipes the copy to free before comparing
                if (cmd == CMD_START) begin
                    for (int i = 0; i < PROCS; i++) stored_states[i] = 2'b00;
                end
                changed = 1'b0;
                for (int i = 0; i < PROCS; i++) begin
                    s = proc_state(ps, i);
                    if (stored_states[i] != s) changed = 1'b1;
                    stored_states[i] = s;
                end
                if (!changed) tag = TAG_NONE;
                else tag = (cmd == CMD_START) ? TAG_INIT : TAG_EDIT;
            end
            default: return 0;
        endcase
        rec_bytes[0] = tag;
        rec_bytes[1] = cnt[15:8];
        rec_bytes[2] = cnt[7:0];
        n = HDR_BYTES;
        if (tag == TAG_CHAR) begin
            rec_bytes[n] = val[7:0];
            n++;
        end else if (tag == TAG_SYSCALL) begin
            rec_bytes[n] = {val[11:8], val[3:0]};
            n++;
        end else if (tag == TAG_INIT || tag == TAG_EDIT) begin
            // four processes per byte, first of the group on top
            for (int g = 0; g < PROCS; g += 4) begin
                packed_b = 8'h00;
                for (int k = 0; k < 4; k++) begin
                    if (g + k < PROCS)
                        packed_b = packed_b | (8'(proc_state(ps, g + k)) << (6 - 2 * k));
                end
                rec_bytes[n] = packed_b;
                n++;
            end
        end
        return n;
    endfunction

    function automatic void add_row(input logic en, input logic [3:0] cmd,
                                    input logic [15:0] val, input logic [15:0] cnt,
                                    input logic [31:0] ps, input int nexp,
                                    input logic [55:0] exp);
        t_event_row row;
        row.en   = en;
        row.cmd  = cmd;
        row.val  = val;
        row.cnt  = cnt;
        row.ps   = ps;
        row.nexp = nexp;
        row.exp  = exp;
        event_plan.push_back(row);
    endfunction

    // offer one event, queue its record once the transaction is accepted
    task automatic send_event(input t_event_row row);
        int          gap;
        int          nrec;
        t_trace_byte tb;
        if (rush_left > 0) begin
            gap = 0;
            rush_left--;
        end else begin
            gap = draw_gap(source_burst);
        end
        if (gap > 0) begin
            evt_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        evt_if.valid          <= 1'b1;
        evt_if.command        <= row.cmd;
        evt_if.event_value    <= row.val;
        evt_if.timer_count    <= row.cnt;
        evt_if.process_states <= row.ps;
        do @(posedge clk); while (!(evt_if.valid && evt_if.ready));
        nrec = encode_event(row.cmd, row.val, row.cnt, row.ps);
        if (row.nexp != PREDICT) begin
            for (int k = 0; k < row.nexp; k++) begin
                tb.byte_val = row.exp[55 - 8 * k -: 8];
                tb.is_last  = (k == row.nexp - 1);
                trace_expect.push_back(tb);
            end
        end else begin
            for (int k = 0; k < nrec; k++) begin
                tb.byte_val = rec_bytes[k];
                tb.is_last  = (k == nrec - 1);
                trace_expect.push_back(tb);
            end
        end
    endtask

    // stop offering and let every outstanding record drain
    task automatic settle_idle();
        evt_if.valid <= 1'b0;
        while (trace_expect.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic en);
        settle_idle();
        cfg_if.valid        <= 1'b1;
        cfg_if.trace_enable <= en;
        do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
        trace_en = en;
        cfg_if.valid <= 1'b0;
    endtask

    // random events, about half state traffic that walks from the last states sent
    task automatic send_random(input int count);
        t_event_row row;
        int         idx;
        for (int n = 0; n < count; n++) begin
            row.en   = trace_en;
            row.val  = 16'($urandom);
            row.cnt  = 16'($urandom);
            row.ps   = $urandom;
            row.nexp = PREDICT;
            row.exp  = 56'h0;
            idx      = $urandom_range(0, 99);
            if (idx < 47) begin
                row.cmd = (idx < 35) ? CMD_STATE : CMD_START;
                case ($urandom_range(0, 3))
                    0: row.ps = last_states;
                    1: begin
                        idx    = $urandom_range(0, FIELD_PROCS - 1);
                        row.ps = last_states ^ (32'($urandom_range(1, 3)) << (2 * idx));
                    end
                    2: row.ps = 32'h0;
                    default: ;
                endcase
                last_states = row.ps;
            end else if (idx < 92) begin
                row.cmd = 4'($urandom_range(CMD_TIMER, CMD_END));
                if (row.cmd == CMD_KEYBOARD && $urandom_range(0, 3) == 0) row.val = 16'h0000;
            end else begin
                row.cmd = 4'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
            end
            send_event(row);
        end
    endtask

    // directed table: disabled events first, then every command and the state corner cases
    initial begin
        add_row(1'b0, CMD_TIMER,     16'hFFFF, 16'h1234, 32'h0,        0, 56'h0);
        add_row(1'b0, CMD_STATE,     16'h0000, 16'h4321, 32'hFFFFFFFF, 0, 56'h0);
        add_row(1'b1, CMD_TIMER,     16'h0000, 16'h0000, 32'h0, 3, {TAG_TIMER, 16'h0000, 32'h0});
        add_row(1'b1, CMD_MOUSE,     16'hFFFF, 16'hFFFF, 32'h0, 3, {TAG_MOUSE, 16'hFFFF, 32'h0});
        add_row(1'b1, CMD_KEYBOARD,  16'h0000, 16'h1234, 32'h0, 3, {TAG_KEY, 16'h1234, 32'h0});
        add_row(1'b1, CMD_KEYBOARD,  16'hFFFF, 16'h8001, 32'h0, 4,
                {TAG_CHAR, 16'h8001, 8'hFF, 24'h0});
        add_row(1'b1, CMD_KEYBOARD,  16'h0100, 16'h0001, 32'h0, 4,
                {TAG_CHAR, 16'h0001, 8'h00, 24'h0});
        add_row(1'b1, CMD_SERIAL,    16'h5A5A, 16'hABCD, 32'h0, 3, {TAG_KEY, 16'hABCD, 32'h0});
        add_row(1'b1, CMD_RX_CHAR,   16'h0041, 16'h0002, 32'h0, 0, 56'h0);
        add_row(1'b1, CMD_TX_CHAR,   16'hFFFF, 16'hFFFF, 32'h0, 0, 56'h0);
        add_row(1'b1, CMD_SYSCALL,   16'hFFFF, 16'h00FF, 32'h0, 4,
                {TAG_SYSCALL, 16'h00FF, 8'hFF, 24'h0});
        add_row(1'b1, CMD_SYSCALL,   16'h0A05, 16'h5555, 32'h0, 4,
                {TAG_SYSCALL, 16'h5555, 8'hA5, 24'h0});
        add_row(1'b1, CMD_SYSCALL,   16'hF0F0, 16'hAAAA, 32'h0, 4,
                {TAG_SYSCALL, 16'hAAAA, 8'h00, 24'h0});
        add_row(1'b1, CMD_END,       16'h1111, 16'hFFFF, 32'h0, 3, {TAG_END, 16'hFFFF, 32'h0});
        // disabled state event above must not have touched the copy
        add_row(1'b1, CMD_STATE,     16'h0000, 16'h0010, 32'h0, 3, {TAG_NONE, 16'h0010, 32'h0});
        add_row(1'b1, CMD_STATE,     16'h0000, 16'h0011, 32'hFFFFFFFF, 7,
                {TAG_EDIT, 16'h0011, 32'hFFFFFFFF});
        add_row(1'b1, CMD_STATE,     16'h0000, 16'h0012, 32'hFFFFFFFF, 3,
                {TAG_NONE, 16'h0012, 32'h0});
        add_row(1'b1, CMD_STATE,     16'hFFFF, 16'h0013, 32'h1B1B1B1B, PREDICT, 56'h0);
        // start with all processes free sees no change after wiping the copy
        add_row(1'b1, CMD_START,     16'h0000, 16'h0014, 32'h0, 3, {TAG_NONE, 16'h0014, 32'h0});
        add_row(1'b1, CMD_START,     16'h0000, 16'h0015, 32'hE4E4E4E4, 7,
                {TAG_INIT, 16'h0015, 32'hE4E4E4E4});
        add_row(1'b1, CMD_START,     16'h0000, 16'h0016, 32'hE4E4E4E4, 7,
                {TAG_INIT, 16'h0016, 32'hE4E4E4E4});
        add_row(1'b1, CMD_STATE,     16'h0000, 16'h0017, 32'h00000001, 7,
                {TAG_EDIT, 16'h0017, 32'h00000001});
        add_row(1'b1, CMD_STATE,     16'h0000, 16'h0018, 32'h40000000, PREDICT, 56'h0);
        add_row(1'b1, CMD_UNUSED_LO, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 0, 56'h0);
        add_row(1'b1, CMD_UNUSED_HI, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 0, 56'h0);
        add_row(1'b1, CMD_STATE,     16'h0000, 16'h0019, 32'h9C3A5E71, PREDICT, 56'h0);
    end

    // main sequence
    initial begin : stimulus
        rst_n                 = 1'b0;
        evt_if.valid          = 1'b0;
        evt_if.command        = CMD_TIMER;
        evt_if.event_value    = 16'h0;
        evt_if.timer_count    = 16'h0;
        evt_if.process_states = 32'h0;
        cfg_if.valid          = 1'b0;
        cfg_if.trace_enable   = 1'b0;
        rec_if.ready          = 1'b0;
        trace_en              = 1'b0;
        for (int i = 0; i < PROCS; i++) stored_states[i] = 2'b00;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (event_plan[i]) begin
            if (event_plan[i].en != trace_en) cfg_write(event_plan[i].en);
            send_event(event_plan[i]);
        end

        send_random(40);
        // long sink stall while events keep coming back to back
        hold_request = 400;
        rush_left    = 30;
        send_random(60);
        settle_idle();
        send_random(60);
        cfg_write(1'b0);
        send_random(40);
        cfg_write(1'b1);
        send_random(240);

        settle_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // trace byte sink with random stalls and one long hold-off
    initial begin : trace_sink
        int          stall;
        t_trace_byte want;
        while (rst_n !== 1'b1) @(posedge clk);
        forever begin
            if (hold_request > 0) begin
                rec_if.ready <= 1'b0;
                repeat (hold_request) @(posedge clk);
                hold_request = 0;
            end
            stall = draw_gap(sink_burst);
            if (stall > 0) begin
                rec_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rec_if.ready <= 1'b1;
            do @(posedge clk); while (!(rec_if.valid && rec_if.ready));
            if (trace_expect.size() == 0) begin
                $error("trace_byte: expected none, actual %h", rec_if.trace_byte);
                err_count++;
            end else begin
                want = trace_expect.pop_front();
                if (rec_if.trace_byte !== want.byte_val) begin
                    $error("trace_byte: expected %h, actual %h", want.byte_val,
                           rec_if.trace_byte);
                    err_count++;
                end
                if (rec_if.last_byte !== want.is_last) begin
                    $error("last_byte: expected %b, actual %b", want.is_last,
                           rec_if.last_byte);
                    err_count++;
                end
            end
        end
    end

    // run time guard
    initial begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
